// ----- hw/rtl/rgb3_pkg.sv -----
// ----------------------------------------------------------------------------
// rgb3_pkg
// Shared types and constants of the 3x3 RGB convolution filter.
// ----------------------------------------------------------------------------
package rgb3_pkg;

  localparam int CH_W         = 8;
  localparam int PIX_W        = 3 * CH_W;
  localparam int COEF_W       = 16;
  localparam int PROD_W       = COEF_W + CH_W + 1;
  localparam int SUM_W        = PROD_W + 4;
  localparam int NUM_TAPS     = 9;
  localparam int MAX_HEIGHT   = 4096;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ROW_W        = 13;
  localparam int CFG_DATA_W   = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_RIGHT  = 3'd4;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_DATA_W-1:0]   COEFF_RESET  = 48'h01C7_01C7_01C7;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CH_W-1:0] CHAN_MAX = 8'd255;

  typedef logic [PIX_W-1:0] pixel_t;

  // one kernel column per entry, top row in the low bits
  typedef logic [2:0][CFG_DATA_W-1:0] coeff_bank_t;

  // tap index is column * 3 + row
  typedef struct packed {
    pixel_t [NUM_TAPS-1:0] tap;
    logic                  last;
  } tap_set_t;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  width;
    logic [HEIGHT_REG_W-1:0] height;
    logic                    restart;
  } geom_t;

endpackage

// ----- hw/rtl/rgb3_if.sv -----
// ----------------------------------------------------------------------------
// rgb3_if
// Pixel channels of the convolution filter: input items and result items.
// ----------------------------------------------------------------------------
interface rgb3_in_if;
  import rgb3_pkg::*;

  logic            valid;
  logic            ready;
  logic            opcode;
  logic [CH_W-1:0] pixel_red;
  logic [CH_W-1:0] pixel_green;
  logic [CH_W-1:0] pixel_blue;

  modport source (output valid, opcode, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, opcode, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface rgb3_out_if;
  import rgb3_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

// ----- hw/rtl/rgb3_ram.sv -----
// ----------------------------------------------------------------------------
// rgb3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/rgb3_front.sv -----
// ----------------------------------------------------------------------------
// rgb3_front
// Accepts pixel items, tracks the raster position, runs the line stores and
// the window and hands masked 3x3 tap sets to the queue.
// ----------------------------------------------------------------------------
module rgb3_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rgb3_pkg::geom_t             geom,
  input  logic [rgb3_pkg::QCNT_W-1:0] q_count,
  rgb3_in_if.sink                     in_px,
  output logic                        q_push,
  output rgb3_pkg::tap_set_t          q_data
);
  import rgb3_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = CW + 1;
  localparam int CMPW = (EW > WIDTH_REG_W) ? EW : WIDTH_REG_W;
  localparam int OCCW = QCNT_W + 1;

  typedef struct packed {
    logic valid;
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic last;
  } cls_t;

  logic [CMPW-1:0]    width_ext;
  logic [EW-1:0]      eff_w;
  logic [CW-1:0]      wm1;
  logic [ROW_W-1:0]   eff_h;
  logic [ROW_W:0]     h1;
  logic [ROW_W:0]     row_ext;

  logic [CW-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               c0;
  cls_t               cls;
  logic               in_fire;
  pixel_t             x_in;

  logic               s1_v_r;
  cls_t               s1_cls_r;
  logic [CW-1:0]      s1_addr_r;
  pixel_t             s1_x_r;
  logic               fwd_sel_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic               s1_push;

  logic [2*PIX_W-1:0] ram_q;
  logic [2*PIX_W-1:0] line_rd;
  logic [2*PIX_W-1:0] line_wr;
  pixel_t             pa, pb;
  pixel_t [5:0]       wnd_r;
  pixel_t [2:0][2:0]  raw;

  // effective geometry
  always_comb begin
    width_ext = CMPW'(geom.width);
    if (width_ext == '0) begin
      eff_w = EW'(1);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_ext);
    end
    wm1 = CW'(eff_w - EW'(1));

    if (geom.height == '0) begin
      eff_h = ROW_W'(1);
    end else if (geom.height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = geom.height;
    end
    h1 = {1'b0, eff_h} + (ROW_W + 1)'(1);
  end

  assign s1_push     = s1_v_r & s1_cls_r.valid;
  assign in_px.ready = ({1'b0, q_count} + OCCW'(s1_push)) < OCCW'(QUEUE_DEPTH);
  assign in_fire     = in_px.valid & in_px.ready;
  assign x_in        = (in_px.opcode == OP_DRAIN) ? '0 :
                       {in_px.pixel_red, in_px.pixel_green, in_px.pixel_blue};

  // column 0 emits the last pixel of the row two rows up, other columns
  // the previous pixel of the row above
  always_comb begin
    c0         = (col_r == '0);
    row_ext    = {1'b0, row_r};
    cls.valid  = c0 ? (row_r >= ROW_W'(2)) : (row_r != '0);
    cls.left   = c0 ? (wm1 == '0) : (col_r == CW'(1));
    cls.right  = c0;
    cls.top    = c0 ? (row_r == ROW_W'(2)) : (row_r == ROW_W'(1));
    cls.bottom = c0 ? (row_ext == h1) : (row_r == eff_h);
    cls.last   = c0 & (row_ext == h1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    priority if (geom.restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (cls.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == wm1) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      fwd_sel_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= in_fire;
      if (in_fire) begin
        fwd_sel_r <= s1_v_r && (s1_addr_r == col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cls_r   <= cls;
      s1_addr_r  <= col_r;
      s1_x_r     <= x_in;
      fwd_data_r <= line_wr;
    end
  end

  // entry holds {upper, lower} for one column
  rgb3_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk    (clk),
    .wr_en  (s1_v_r),
    .wr_addr(s1_addr_r),
    .wr_data(line_wr),
    .rd_en  (in_fire),
    .rd_addr(col_r),
    .rd_data(ram_q)
  );

  // back-to-back items on the same column see the word still being written
  assign line_rd = fwd_sel_r ? fwd_data_r : ram_q;
  assign pa      = line_rd[2*PIX_W-1:PIX_W];
  assign pb      = line_rd[PIX_W-1:0];
  assign line_wr = {pb, s1_x_r};

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      wnd_r[2:0] <= wnd_r[5:3];
      wnd_r[3]   <= pa;
      wnd_r[4]   <= pb;
      wnd_r[5]   <= s1_x_r;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      raw[0][j] = wnd_r[j];
      raw[1][j] = wnd_r[3+j];
    end
    raw[2][0] = pa;
    raw[2][1] = pb;
    raw[2][2] = s1_x_r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i == 0 && s1_cls_r.left) || (i == 2 && s1_cls_r.right) ||
            (j == 0 && s1_cls_r.top) || (j == 2 && s1_cls_r.bottom)) begin
          q_data.tap[i*3+j] = '0;
        end else begin
          q_data.tap[i*3+j] = raw[i][j];
        end
      end
    end
    q_data.last = s1_cls_r.last;
  end

  assign q_push = s1_push;

endmodule

// ----- hw/rtl/rgb3_queue.sv -----
// ----------------------------------------------------------------------------
// rgb3_queue
// Short FIFO of tap sets between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module rgb3_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  rgb3_pkg::tap_set_t          push_data,
  input  logic                        pop,
  output rgb3_pkg::tap_set_t          pop_data,
  output logic                        nonempty,
  output logic [rgb3_pkg::QCNT_W-1:0] count
);
  import rgb3_pkg::*;

  tap_set_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign pop_data = mem_r[rd_ptr_r];
  assign nonempty = (count_r != '0);
  assign count    = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rgb3_back.sv -----
// ----------------------------------------------------------------------------
// rgb3_back
// Kernel arithmetic: products, channel sums, clamp and output register.
// ----------------------------------------------------------------------------
module rgb3_back #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgb3_pkg::coeff_bank_t coeffs,
  input  logic                 q_nonempty,
  input  rgb3_pkg::tap_set_t   q_data,
  output logic                 q_pop,
  rgb3_out_if.source           out_px
);
  import rgb3_pkg::*;

  logic signed [2:0][NUM_TAPS-1:0][PROD_W-1:0] prod_nxt, prod_r;
  logic signed [2:0][SUM_W-1:0]                sum_nxt, sum_r;
  logic [2:0][CH_W-1:0]                        chan_nxt, chan_r;
  logic signed [SUM_W-1:0]                     q;
  logic a_v_r, b_v_r, o_v_r;
  logic a_last_r, b_last_r, o_last_r;
  logic a_ready, b_ready, o_ready;

  assign o_ready = !o_v_r | out_px.ready;
  assign b_ready = !b_v_r | o_ready;
  assign a_ready = !a_v_r | b_ready;
  assign q_pop   = q_nonempty & a_ready;

  // channel 0 is red in the top byte
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_nxt[ch][i*3+j] =
            PROD_W'($signed(coeffs[i][j*COEF_W +: COEF_W])) *
            PROD_W'($signed({1'b0, q_data.tap[i*3+j][(2-ch)*CH_W +: CH_W]}));
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
      for (int k = 0; k < NUM_TAPS; k++) begin
        sum_nxt[ch] = sum_nxt[ch] + SUM_W'($signed(prod_r[ch][k]));
      end
    end
  end

  // negative sums give zero, otherwise drop the fraction and saturate
  always_comb begin
    q = '0;
    for (int ch = 0; ch < 3; ch++) begin
      q = sum_r[ch] >>> COEF_FRAC_BITS;
      if (sum_r[ch][SUM_W-1]) begin
        chan_nxt[ch] = '0;
      end else if (q > SUM_W'(CHAN_MAX)) begin
        chan_nxt[ch] = CHAN_MAX;
      end else begin
        chan_nxt[ch] = q[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_r <= q_nonempty;
      end
      if (b_ready) begin
        b_v_r <= a_v_r;
      end
      if (o_ready) begin
        o_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r   <= prod_nxt;
      a_last_r <= q_data.last;
    end
    if (a_v_r && b_ready) begin
      sum_r    <= sum_nxt;
      b_last_r <= a_last_r;
    end
    if (b_v_r && o_ready) begin
      chan_r   <= chan_nxt;
      o_last_r <= b_last_r;
    end
  end

  assign out_px.valid     = o_v_r;
  assign out_px.out_red   = chan_r[0];
  assign out_px.out_green = chan_r[1];
  assign out_px.out_blue  = chan_r[2];
  assign out_px.frame_end = o_last_r;

endmodule

// ----- hw/rtl/rgb_3x3_convolution_filter_core.sv -----
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_filter_core
//
// Filters a raster-order RGB stream with a 3x3 kernel of signed Q4.12
// coefficients, treating everything outside the image as black and clamping
// each channel to 0..255. One item is taken per clock while the output is not
// stalled; the rate is set by the line store, a single RAM of {upper, lower}
// words per column that is read and rewritten once per item, and by the
// nine-tap multiply stage. The result for a pixel leaves one row plus one
// pixel after that pixel came in, so width+1 drain items flush the last row;
// inside the block an item passes from acceptance through the line store
// read, the tap queue, the products, the sums and the clamp to the output
// register. The line store needs no clearing pass after reset: every entry
// is written within a frame before it is read unmasked. Geometry writes
// restart the frame; write registers only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_filter_core #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [rgb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgb3_pkg::CFG_DATA_W-1:0] cfg_wdata,
  rgb3_in_if.sink                         in_px,
  rgb3_out_if.source                      out_px
);
  import rgb3_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  coeff_bank_t             coeff_r;
  geom_t                   geom;

  tap_set_t                q_in, q_out;
  logic                    q_push, q_pop, q_nonempty;
  logic [QCNT_W-1:0]       q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      coeff_r  <= {3{COEFF_RESET}};
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r    <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r   <= cfg_wdata[HEIGHT_REG_W-1:0];
        REG_COEFF_LEFT:   coeff_r[0] <= cfg_wdata;
        REG_COEFF_MIDDLE: coeff_r[1] <= cfg_wdata;
        REG_COEFF_RIGHT:  coeff_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign geom.width   = width_r;
  assign geom.height  = height_r;
  assign geom.restart = cfg_wr_en &&
                        (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  rgb3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .geom   (geom),
    .q_count(q_count),
    .in_px  (in_px),
    .q_push (q_push),
    .q_data (q_in)
  );

  rgb3_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .nonempty (q_nonempty),
    .count    (q_count)
  );

  rgb3_back #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coeffs    (coeff_r),
    .q_nonempty(q_nonempty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_px    (out_px)
  );

endmodule

// ----- hw/rtl/rgb3_checker.sv -----
// ----------------------------------------------------------------------------
// rgb3_checker
// Port-level checks of the convolution filter, bound to the top level.
// ----------------------------------------------------------------------------
module rgb3_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rgb3_pkg::CH_W-1:0] out_red,
  input logic [rgb3_pkg::CH_W-1:0] out_green,
  input logic [rgb3_pkg::CH_W-1:0] out_blue,
  input logic                      frame_end
);
  import rgb3_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_red, out_green, out_blue, frame_end}))
    else $error("result item changed while stalled");

  // reset empties the result side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a draining sink frees room in the tap queue by the following cycle
  a_ready_recovers: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |=> in_ready)
    else $error("input held off although the output drains");

endmodule

bind rgb_3x3_convolution_filter_core rgb3_checker u_rgb3_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_px.ready),
  .out_valid(out_px.valid),
  .out_ready(out_px.ready),
  .out_red  (out_px.out_red),
  .out_green(out_px.out_green),
  .out_blue (out_px.out_blue),
  .frame_end(out_px.frame_end)
);
